FILE: rtl/i2a_pkg.sv
package i2a_pkg;

  localparam logic [2:0] CMD_HEX32 = 3'd0;
  localparam logic [2:0] CMD_HEX16 = 3'd1;
  localparam logic [2:0] CMD_HEX64 = 3'd2;
  localparam logic [2:0] CMD_PTR   = 3'd3;
  localparam logic [2:0] CMD_UDEC  = 3'd4;
  localparam logic [2:0] CMD_SDEC  = 3'd5;

  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_X         = 8'h78;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [7:0] HEX_UPPER_OFS  = 8'h37;
  localparam logic [7:0] HEX_LOWER_OFS  = 8'h57;
  localparam logic [31:0] SIGN_BIT      = 32'h8000_0000;

  localparam int NUM_DIGITS = 10;
  localparam int NUM_SLOTS  = 16;
  localparam int DABBLE_PER_STAGE = 8;

  typedef struct packed {
    logic [2:0]  command;
    logic        upper_case;
    logic [63:0] value;
  } i2a_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
  } i2a_result_t;

  typedef struct packed {
    logic [2:0]  command;
    logic        upper_case;
    logic [63:0] value;
    logic        neg;
    logic [31:0] bin;
    logic [39:0] bcd;
  } i2a_work_t;

endpackage

FILE: rtl/i2a_front.sv
module i2a_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  i2a_pkg::i2a_item_t  up,
  output logic                down_valid,
  input  logic                down_ready,
  output i2a_pkg::i2a_work_t  down
);

  logic               valid;
  i2a_pkg::i2a_work_t work;
  i2a_pkg::i2a_work_t work_next;
  logic [31:0]        low32;

  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;
  assign down       = work;
  assign low32      = up.value[31:0];

  always_comb begin
    work_next.command    = up.command;
    work_next.upper_case = up.upper_case;
    work_next.value      = up.value;
    work_next.neg        = (up.command == i2a_pkg::CMD_SDEC) &&
                           ((low32 & i2a_pkg::SIGN_BIT) != 32'd0);
    work_next.bin        = work_next.neg ? (~low32 + 32'd1) : low32;
    work_next.bcd        = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      work <= work_next;
    end
  end

endmodule

FILE: rtl/i2a_dabble.sv
module i2a_dabble (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  i2a_pkg::i2a_work_t  up,
  output logic                down_valid,
  input  logic                down_ready,
  output i2a_pkg::i2a_work_t  down
);

  logic               valid;
  i2a_pkg::i2a_work_t work;
  i2a_pkg::i2a_work_t work_next;

  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;
  assign down       = work;

  always_comb begin
    work_next = up;
    for (int s = 0; s < i2a_pkg::DABBLE_PER_STAGE; s++) begin
      for (int d = 0; d < i2a_pkg::NUM_DIGITS; d++) begin
        if (work_next.bcd[4*d +: 4] >= 4'd5) begin
          work_next.bcd[4*d +: 4] = work_next.bcd[4*d +: 4] + 4'd3;
        end
      end
      {work_next.bcd, work_next.bin} = {work_next.bcd[38:0], work_next.bin, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      work <= work_next;
    end
  end

endmodule

FILE: rtl/i2a_emit.sv
module i2a_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  i2a_pkg::i2a_work_t   up,
  output logic                 result_valid,
  input  logic                 result_ready,
  output i2a_pkg::i2a_result_t result
);

  localparam logic [3:0] LAST_POS = 4'd15;

  logic       busy;
  logic [3:0] idx;
  logic [7:0] chars [i2a_pkg::NUM_SLOTS];
  logic [7:0] chars_next [i2a_pkg::NUM_SLOTS];
  logic [3:0] first_next;
  logic       ok_next;
  logic       last;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] ofs;
    ofs = upper ? i2a_pkg::HEX_UPPER_OFS : i2a_pkg::HEX_LOWER_OFS;
    if (nib < 4'd10) begin
      return i2a_pkg::CHAR_ZERO + {4'd0, nib};
    end
    return ofs + {4'd0, nib};
  endfunction

  always_comb begin
    ok_next    = 1'b1;
    first_next = LAST_POS;
    for (int p = 0; p < i2a_pkg::NUM_SLOTS; p++) begin
      chars_next[p] = hex_char(up.value[4*(15-p) +: 4], up.upper_case);
    end
    case (up.command)
      i2a_pkg::CMD_HEX32: begin
        for (int p = 15; p >= 8; p--) begin
          if (up.value[4*(15-p) +: 4] != 4'd0) begin
            first_next = 4'(p);
          end
        end
      end
      i2a_pkg::CMD_HEX16: begin
        for (int p = 15; p >= 12; p--) begin
          if (up.value[4*(15-p) +: 4] != 4'd0) begin
            first_next = 4'(p);
          end
        end
      end
      i2a_pkg::CMD_HEX64: begin
        first_next = 4'd0;
      end
      i2a_pkg::CMD_PTR: begin
        first_next    = 4'd6;
        chars_next[6] = i2a_pkg::CHAR_ZERO;
        chars_next[7] = i2a_pkg::CHAR_X;
      end
      i2a_pkg::CMD_UDEC, i2a_pkg::CMD_SDEC: begin
        for (int p = 15; p >= 6; p--) begin
          chars_next[p] = i2a_pkg::CHAR_ZERO + {4'd0, up.bcd[4*(15-p) +: 4]};
          if (up.bcd[4*(15-p) +: 4] != 4'd0) begin
            first_next = 4'(p);
          end
        end
        if (up.neg) begin
          first_next             = first_next - 4'd1;
          chars_next[first_next] = i2a_pkg::CHAR_MINUS;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  assign last         = (idx == LAST_POS);
  assign up_ready     = !busy || (result_ready && last);
  assign result_valid = busy;
  assign result.character = chars[idx];
  assign result.is_last   = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (up_ready) begin
      busy <= up_valid && ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      idx   <= first_next;
      chars <= chars_next;
    end else if (result_ready) begin
      idx <= idx + 4'd1;
    end
  end

endmodule

FILE: rtl/integer_to_ascii_formatter_core.sv
// The first character is valid once the item has passed all six register stages.
// Throughput: one character per cycle while result_ready is high; an item of n characters
//   (1 to 16) is followed with no gap by a waiting next item with a valid command.
// Six register stages: input/negate, four shift-add-3 stages of 8 bits each, emit buffer.
// Reset (rst, synchronous) clears every stage valid bit; no item survives reset.
module integer_to_ascii_formatter_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  i2a_pkg::i2a_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output i2a_pkg::i2a_result_t result
);

  localparam int NUM_STAGES = 32 / i2a_pkg::DABBLE_PER_STAGE;

  logic               stg_valid [NUM_STAGES+1];
  logic               stg_ready [NUM_STAGES+1];
  i2a_pkg::i2a_work_t stg_work  [NUM_STAGES+1];

  i2a_front u_front (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (item_valid),
    .up_ready   (item_ready),
    .up         (item),
    .down_valid (stg_valid[0]),
    .down_ready (stg_ready[0]),
    .down       (stg_work[0])
  );

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
    i2a_dabble u_dabble (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (stg_valid[g]),
      .up_ready   (stg_ready[g]),
      .up         (stg_work[g]),
      .down_valid (stg_valid[g+1]),
      .down_ready (stg_ready[g+1]),
      .down       (stg_work[g+1])
    );
  end

  i2a_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (stg_valid[NUM_STAGES]),
    .up_ready     (stg_ready[NUM_STAGES]),
    .up           (stg_work[NUM_STAGES]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: rtl/i2a_checker.sv
module i2a_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input i2a_pkg::i2a_item_t   item,
  input logic                 result_valid,
  input logic                 result_ready,
  input i2a_pkg::i2a_result_t result
);

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("input transaction dropped or changed while stalled");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result transaction dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.character >= i2a_pkg::CHAR_MINUS &&
                     result.character <= 8'h7A)
    else $error("character outside the printable set of the formatter");

  a_prefix_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.character == i2a_pkg::CHAR_X ||
                     result.character == i2a_pkg::CHAR_MINUS) |-> !result.is_last)
    else $error("prefix or sign marked as the final character");

endmodule

bind integer_to_ascii_formatter_core i2a_checker u_i2a_checker (.*);

FILE: tb/sv/tb_integer_to_ascii_formatter_core.sv
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter_core;

  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;
  localparam int RANDOM_ITEMS = 180;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    i2a_pkg::i2a_item_t item;
    bit                 typed;
    string              text;
  } directed_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  i2a_pkg::i2a_item_t   item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  i2a_pkg::i2a_result_t result;

  directed_row_t        directed_rows[$];
  i2a_pkg::i2a_result_t pending_chars[$];
  i2a_pkg::i2a_result_t next_char;
  int                   failures = 0;
  int                   accepted_items = 0;
  int                   burst_left = 1;
  bit                   held_off = 1'b0;

  integer_to_ascii_formatter_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500_000;
    $display("tb_integer_to_ascii_formatter_core failed");
    $finish;
  end

  function automatic logic [7:0] hex_digit(logic [3:0] nib, logic upper);
    if (nib < 4'd10) begin
      return i2a_pkg::CHAR_ZERO + {4'h0, nib};
    end
    return {4'h0, nib} + (upper ? i2a_pkg::HEX_UPPER_OFS : i2a_pkg::HEX_LOWER_OFS);
  endfunction

  function automatic void predict_chars(i2a_pkg::i2a_item_t it);
    logic [7:0]  text[$];
    logic [31:0] mag;
    logic [3:0]  nib;
    int          ndig;
    int          base;
    bit          lead;
    mag = it.value[31:0];
    case (it.command)
      i2a_pkg::CMD_HEX32, i2a_pkg::CMD_HEX16, i2a_pkg::CMD_HEX64, i2a_pkg::CMD_PTR: begin
        ndig = (it.command == i2a_pkg::CMD_HEX16) ? 4 :
               (it.command == i2a_pkg::CMD_HEX64) ? 16 : 8;
        lead = (it.command == i2a_pkg::CMD_HEX32) || (it.command == i2a_pkg::CMD_HEX16);
        if (it.command == i2a_pkg::CMD_PTR) begin
          text.push_back(i2a_pkg::CHAR_ZERO);
          text.push_back(i2a_pkg::CHAR_X);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
          nib = it.value[4*i +: 4];
          if (!(lead && nib == 4'h0 && i != 0)) begin
            lead = 1'b0;
            text.push_back(hex_digit(nib, it.upper_case));
          end
        end
      end
      i2a_pkg::CMD_UDEC, i2a_pkg::CMD_SDEC: begin
        if (it.command == i2a_pkg::CMD_SDEC && (mag & i2a_pkg::SIGN_BIT) != 0) begin
          text.push_back(i2a_pkg::CHAR_MINUS);
          mag = ~mag + 32'd1;
        end
        base = text.size();
        do begin
          text.insert(base, i2a_pkg::CHAR_ZERO + 8'(mag % 32'd10));
          mag = mag / 32'd10;
        end while (mag != 0);
      end
      default: ;
    endcase
    foreach (text[k]) begin
      pending_chars.push_back('{character: text[k], is_last: (k == text.size() - 1)});
    end
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back('{character: s[i], is_last: (i == s.len() - 1)});
    end
  endfunction

  function automatic directed_row_t stim_row(logic [2:0] cmd, logic upper,
                                             logic [63:0] value, bit typed, string text);
    directed_row_t r;
    r.item  = '{command: cmd, upper_case: upper, value: value};
    r.typed = typed;
    r.text  = text;
    return r;
  endfunction

  function automatic logic [63:0] random_value();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 20));
      2: return {$urandom, $urandom} >> $urandom_range(0, 63);
      3: return {$urandom, i2a_pkg::SIGN_BIT + 32'($urandom_range(0, 3)) - 32'd2};
      4: begin
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        return {$urandom, p - 32'($urandom_range(0, 1))};
      end
      default: return {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(0, 3))};
    endcase
  endfunction

  task automatic send_item(i2a_pkg::i2a_item_t it, bit typed, string text);
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    accepted_items++;
    if (typed) begin
      push_text(text);
    end else begin
      predict_chars(it);
    end
    burst_left--;
    if (burst_left <= 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: expected none, actual %h", result.character);
        failures++;
      end else begin
        next_char = pending_chars.pop_front();
        if (result.character !== next_char.character) begin
          $error("character: expected %h, actual %h", next_char.character, result.character);
          failures++;
        end
        if (result.is_last !== next_char.is_last) begin
          $error("is_last: expected %b, actual %b", next_char.is_last, result.is_last);
          failures++;
        end
      end
    end
  end

  initial begin
    int style;
    int span;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && accepted_items >= directed_rows.size() + 40) begin
        held_off = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      style = $urandom_range(0, 3);
      span  = $urandom_range(4, 40);
      repeat (span) begin
        case (style)
          0: result_ready <= 1'b1;
          1: result_ready <= 1'($urandom_range(0, 1));
          2: result_ready <= ($urandom_range(0, 3) != 0);
          default: result_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    i2a_pkg::i2a_item_t it;
    int                 counted;

    directed_rows.push_back(stim_row(i2a_pkg::CMD_HEX32, 1'b1, 64'h0, TYPED, "0"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_HEX32, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
                                     TYPED, "ffffffff"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_HEX32, 1'b1, 64'h1234_0000_00AB_CDEF,
                                     TYPED, "ABCDEF"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_HEX16, 1'b0, 64'h0, TYPED, "0"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_HEX16, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                                     TYPED, "FFFF"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_HEX16, 1'b0, 64'h0000_0000_0001_000A,
                                     TYPED, "a"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_HEX64, 1'b1, 64'h0,
                                     TYPED, "0000000000000000"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_HEX64, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
                                     TYPED, "ffffffffffffffff"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_HEX64, 1'b1, 64'h0123_4567_89AB_CDEF,
                                     TYPED, "0123456789ABCDEF"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_PTR, 1'b1, 64'h0, TYPED, "0x00000000"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_PTR, 1'b1, 64'h0000_0000_DEAD_BEEF,
                                     TYPED, "0xDEADBEEF"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_PTR, 1'b0, 64'hFFFF_FFFF_0000_ABCD,
                                     TYPED, "0x0000abcd"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_UDEC, 1'b0, 64'h0, TYPED, "0"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_UDEC, 1'b1, 64'h0000_0000_FFFF_FFFF,
                                     TYPED, "4294967295"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_UDEC, 1'b1, 64'hFFFF_FFFF_0000_000A,
                                     TYPED, "10"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_SDEC, 1'b0, 64'h0, TYPED, "0"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_SDEC, 1'b0, 64'h0000_0000_8000_0000,
                                     TYPED, "-2147483648"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_SDEC, 1'b1, 64'h0000_0000_FFFF_FFFF,
                                     TYPED, "-1"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_SDEC, 1'b0, 64'h0000_0000_7FFF_FFFF,
                                     TYPED, "2147483647"));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_SDEC, 1'b1, 64'hFFFF_FFFF_0000_0005,
                                     TYPED, "5"));
    directed_rows.push_back(stim_row(CMD_RSVD6, 1'b1, 64'h0000_0000_1234_5678, TYPED, ""));
    directed_rows.push_back(stim_row(CMD_RSVD7, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, TYPED, ""));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_HEX32, 1'b0, 64'h0000_0000_0000_0010,
                                     PREDICTED, ""));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_UDEC, 1'b0, 64'd1000000000,
                                     PREDICTED, ""));
    directed_rows.push_back(stim_row(i2a_pkg::CMD_SDEC, 1'b1, 64'h0000_0000_8000_0001,
                                     PREDICTED, ""));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].text);
    end

    wait_drained();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        it.command = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
      end else begin
        it.command = 3'($urandom_range(i2a_pkg::CMD_HEX32, i2a_pkg::CMD_SDEC));
        counted++;
      end
      it.upper_case = 1'($urandom_range(0, 1));
      it.value      = random_value();
      send_item(it, PREDICTED, "");
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("tb_integer_to_ascii_formatter_core passed");
    end else begin
      $display("tb_integer_to_ascii_formatter_core failed");
    end
    $finish;
  end

endmodule
